@@ design/lz4lm_pkg.sv @@
// Shared types and constants for the LZ4 literal mask parser.
// Holds the parse phase encoding and the byte masks of the sequence format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lz4lm_pkg;

	// Parse phase, one-hot.
	typedef enum logic [4:0] {
		PH_TOKEN     = 5'b00001,
		PH_LIT_EXT   = 5'b00010,
		PH_LITERALS  = 5'b00100,
		PH_OFFSET    = 5'b01000,
		PH_MATCH_EXT = 5'b10000
	} phase_t;

	localparam logic [7:0] TOKEN_LIT_MASK   = 8'hF0;
	localparam logic [7:0] TOKEN_MATCH_MASK = 8'h0F;
	localparam logic [7:0] EXT_CONTINUE     = 8'hFF;
	localparam int unsigned LIT_NIBBLE_SHIFT = 4;
	localparam logic [1:0] OFFSET_BYTES     = 2'd2;

endpackage

`default_nettype wire

@@ design/lz4_literal_mask_parser_core.sv @@
// Top level of the LZ4 literal mask parser: input register, sequence state
// machine and result register. Depends on lz4lm_pkg.
//
// Usage: compressed block bytes enter on the input channel (in_valid / in_stall)
// one word per cycle while in_stall is low, with the flags block_first, block_last and in_block.
// Each accepted word yields exactly one result word on the output channel
// (out_valid / out_stall) carrying literal_mark and token_mark, in order.
// A word passes through the input register and then the result register on
// its way to out_valid. Throughput is one word per cycle while the receiver
// does not stall; the limit is the update of the parse state, which each word
// needs before the next can be parsed.
// Reset (arst_n low) empties both registers and puts the parser in the state
// that expects a token. When the receiver stalls, the result register holds
// its word, the input register fills behind it, and in_stall rises only when
// both are full, so no word is lost or repeated.
// Bytes with in_block low pass through with both marks zero and leave the
// parse state alone.
`timescale 1ns / 1ps
`default_nettype none

module lz4_literal_mask_parser_core #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       block_first,
	input  wire logic       block_last,
	input  wire logic       in_block,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            literal_mark,
	output logic            token_mark
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	logic       inblk_s1;

	// Result register.
	logic valid_s2;
	logic lit_s2;
	logic tok_s2;

	// Parse state.
	lz4lm_pkg::phase_t      phase_q;
	logic [LENGTH_BITS-1:0] lit_rem_q;
	logic                   match_ext_q;
	logic [1:0]             off_left_q;

	lz4lm_pkg::phase_t      phase_d;
	logic [LENGTH_BITS-1:0] lit_rem_d;
	logic                   match_ext_d;
	logic [1:0]             off_left_d;
	logic                   lit_d;
	logic                   tok_d;

	logic                   adv_s2;
	logic                   adv_s1;
	logic                   in_fire;
	lz4lm_pkg::phase_t      phase_eff;
	logic [LENGTH_BITS:0]   lit_sum;
	logic [LENGTH_BITS-1:0] lit_sat;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign in_fire  = in_valid && !in_stall;

	assign out_valid    = valid_s2;
	assign literal_mark = lit_s2;
	assign token_mark   = tok_s2;

	// Saturating add of an extension byte to the literal count.
	assign lit_sum = {1'b0, lit_rem_q} + {{(LENGTH_BITS - 7){1'b0}}, byte_s1};
	assign lit_sat = lit_sum[LENGTH_BITS] ? LEN_MAX : lit_sum[LENGTH_BITS-1:0];

	always_comb begin
		phase_eff   = first_s1 ? lz4lm_pkg::PH_TOKEN : phase_q;
		phase_d     = phase_q;
		lit_rem_d   = lit_rem_q;
		match_ext_d = match_ext_q;
		off_left_d  = off_left_q;
		lit_d       = 1'b0;
		tok_d       = 1'b0;
		if (inblk_s1) begin
			phase_d = phase_eff;
			case (phase_eff)
				lz4lm_pkg::PH_LIT_EXT: begin
					lit_rem_d = lit_sat;
					if (byte_s1 != lz4lm_pkg::EXT_CONTINUE) begin
						if (lit_sat != '0) begin
							phase_d = lz4lm_pkg::PH_LITERALS;
						end else begin
							phase_d    = lz4lm_pkg::PH_OFFSET;
							off_left_d = lz4lm_pkg::OFFSET_BYTES;
						end
					end
				end
				lz4lm_pkg::PH_LITERALS: begin
					lit_d = 1'b1;
					if (lit_rem_q[LENGTH_BITS-1:1] == '0) begin
						lit_rem_d  = '0;
						phase_d    = lz4lm_pkg::PH_OFFSET;
						off_left_d = lz4lm_pkg::OFFSET_BYTES;
					end else begin
						lit_rem_d = lit_rem_q - LENGTH_BITS'(1);
					end
				end
				lz4lm_pkg::PH_OFFSET: begin
					if (off_left_q[1] == 1'b0) begin
						off_left_d = '0;
						phase_d    = match_ext_q ? lz4lm_pkg::PH_MATCH_EXT
						                         : lz4lm_pkg::PH_TOKEN;
					end else begin
						off_left_d = off_left_q - 2'd1;
					end
				end
				lz4lm_pkg::PH_MATCH_EXT: begin
					if (byte_s1 != lz4lm_pkg::EXT_CONTINUE) begin
						phase_d = lz4lm_pkg::PH_TOKEN;
					end
				end
				default: begin
					// Token byte; unused phase codes land here as well.
					tok_d       = 1'b1;
					match_ext_d = (byte_s1 & lz4lm_pkg::TOKEN_MATCH_MASK)
					              == lz4lm_pkg::TOKEN_MATCH_MASK;
					if ((byte_s1 & lz4lm_pkg::TOKEN_LIT_MASK) == lz4lm_pkg::TOKEN_LIT_MASK) begin
						lit_rem_d = LENGTH_BITS'(15);
						phase_d   = lz4lm_pkg::PH_LIT_EXT;
					end else begin
						lit_rem_d = LENGTH_BITS'(byte_s1 >> lz4lm_pkg::LIT_NIBBLE_SHIFT);
						if ((byte_s1 & lz4lm_pkg::TOKEN_LIT_MASK) != 8'h00) begin
							phase_d = lz4lm_pkg::PH_LITERALS;
						end else begin
							phase_d    = lz4lm_pkg::PH_OFFSET;
							off_left_d = lz4lm_pkg::OFFSET_BYTES;
						end
					end
				end
			endcase
			if (last_s1) begin
				phase_d     = lz4lm_pkg::PH_TOKEN;
				lit_rem_d   = '0;
				match_ext_d = 1'b0;
				off_left_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= data_byte;
			first_s1 <= block_first;
			last_s1  <= block_last;
			inblk_s1 <= in_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lit_s2 <= lit_d;
			tok_s2 <= tok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lz4lm_pkg::PH_TOKEN;
			lit_rem_q   <= '0;
			match_ext_q <= 1'b0;
			off_left_q  <= '0;
		end else if (adv_s1) begin
			phase_q     <= phase_d;
			lit_rem_q   <= lit_rem_d;
			match_ext_q <= match_ext_d;
			off_left_q  <= off_left_d;
		end
	end

	// A word in the result register never carries both marks.
	a_marks_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(lit_s2 && tok_s2))
		else $error("literal and token marks both set");

	// While literals are expected, the remaining count is never zero.
	a_literals_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lz4lm_pkg::PH_LITERALS) |-> (lit_rem_q != '0))
		else $error("literal phase with zero count");

	// While offset bytes are expected, at least one remains.
	a_offset_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lz4lm_pkg::PH_OFFSET) |-> (off_left_q != 2'd0))
		else $error("offset phase with zero count");

	// A word that moves out of the input register shows up as a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("word lost between input and result register");

endmodule

`default_nettype wire
